FILE: rtl/fsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_pkg: shared types and constants of the flash write sequencer
// Field widths, operation and result codes, and the item records that move
// between the front, the inter-stage queue and the back.
// ----------------------------------------------------------------------------
package fsq_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned WORDS_W  = 8;
  localparam int unsigned WOFF_W   = 14;
  localparam int unsigned CNT_W    = 16;

  // Depth of the queue between front and back.
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT = 2'd0,
    OP_DONE   = 2'd1,
    OP_TICK   = 2'd2,
    OP_INIT   = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK       = 3'd0,
    KIND_ERASE     = 3'd1,
    KIND_PROGRAM   = 3'd2,
    KIND_DONE_OK   = 3'd3,
    KIND_DONE_ERR  = 3'd4,
    KIND_NOTHING   = 3'd5,
    KIND_INIT_DONE = 3'd6
  } kind_e;

  // Classified item handed from front to back. sector_base is the start of
  // the uniform sector that holds write_offset.
  typedef struct packed {
    op_e                 op;
    logic [OFFSET_W-1:0] write_offset;
    logic [LENGTH_W-1:0] write_length;
    logic                flash_ok;
    logic [OFFSET_W-1:0] sector_base;
  } fsq_item_t;

  // One queued write request.
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [OFFSET_W-1:0] base;
  } fsq_req_t;

endpackage

FILE: rtl/fsq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_req_if: input item channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface fsq_req_if;
  import fsq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [OFFSET_W-1:0] write_offset;
  logic [LENGTH_W-1:0] write_length;
  logic                flash_ok;

  modport source (output valid, output op, output write_offset, output write_length,
                  output flash_ok, input ready);
  modport sink (input valid, input op, input write_offset, input write_length,
                input flash_ok, output ready);
endinterface

FILE: rtl/fsq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_rsp_if: result item channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface fsq_rsp_if;
  import fsq_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic                accepted;
  logic [ADDR_W-1:0]   flash_address;
  logic [WORDS_W-1:0]  word_count;
  logic [WOFF_W-1:0]   data_word_offset;
  logic [CNT_W-1:0]    ok_count;
  logic [CNT_W-1:0]    error_count;

  modport source (output valid, output kind, output accepted, output flash_address,
                  output word_count, output data_word_offset, output ok_count,
                  output error_count, input ready);
  modport sink (input valid, input kind, input accepted, input flash_address,
                input word_count, input data_word_offset, input ok_count,
                input error_count, output ready);
endinterface

FILE: rtl/fsq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_front: intake and sector classification
// Three-stage pipeline that registers each item and finds the start of the
// uniform sector holding its offset (reciprocal multiply, back multiply,
// one correction step).
// ----------------------------------------------------------------------------
module fsq_front #(
  parameter int unsigned PAGE_BYTES   = 512,
  parameter int unsigned SECTOR_PAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fsq_req_if.sink            req_i,
  output logic               out_valid_o,
  output fsq_pkg::fsq_item_t out_item_o,
  input  logic               out_ready_i
);
  import fsq_pkg::*;

  localparam int unsigned SECTOR_BYTES = PAGE_BYTES * SECTOR_PAGES;
  localparam int unsigned RECIP_W      = 19;
  localparam int unsigned SEC_W        = 21;
  localparam int unsigned PROD1_W      = OFFSET_W + RECIP_W;
  localparam int unsigned PROD2_W      = RECIP_W + SEC_W;
  // floor(2^24 / sector); quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((32'd1 << OFFSET_W) / SECTOR_BYTES);
  localparam logic [SEC_W-1:0]   SECTOR = SEC_W'(SECTOR_BYTES);

  logic                  en;
  logic                  v1_q, v2_q, v3_q;
  fsq_item_t             it1_q, it2_q, it3_q;
  logic [RECIP_W-1:0]    quot1_q;
  logic [OFFSET_W:0]     base2_q;
  logic [PROD1_W-1:0]    prod1;
  logic [PROD2_W-1:0]    prod2;
  logic [OFFSET_W:0]     rem2;
  logic [OFFSET_W:0]     base2_fix;
  fsq_item_t             it_in;
  fsq_item_t             it2_fix;

  assign en          = !v3_q || out_ready_i;
  assign req_i.ready = en;

  always_comb begin
    it_in              = '0;
    it_in.op           = op_e'(req_i.op);
    it_in.write_offset = req_i.write_offset;
    it_in.write_length = req_i.write_length;
    it_in.flash_ok     = req_i.flash_ok;
  end

  assign prod1 = PROD1_W'(req_i.write_offset) * PROD1_W'(RECIP);
  assign prod2 = PROD2_W'(quot1_q) * PROD2_W'(SECTOR);

  assign rem2      = {1'b0, it2_q.write_offset} - base2_q;
  assign base2_fix = (rem2 >= (OFFSET_W+1)'(SECTOR)) ? base2_q + (OFFSET_W+1)'(SECTOR)
                                                      : base2_q;

  always_comb begin
    it2_fix             = it2_q;
    it2_fix.sector_base = base2_fix[OFFSET_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      it1_q   <= '0;
      it2_q   <= '0;
      it3_q   <= '0;
      quot1_q <= '0;
      base2_q <= '0;
    end else if (en) begin
      v1_q    <= req_i.valid;
      it1_q   <= it_in;
      quot1_q <= RECIP_W'(prod1 >> OFFSET_W);
      v2_q    <= v1_q;
      it2_q   <= it1_q;
      base2_q <= prod2[OFFSET_W:0];
      v3_q    <= v2_q;
      it3_q   <= it2_fix;
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = it3_q;

endmodule

FILE: rtl/fsq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_fifo: short queue between front and back
// Small register FIFO of classified items.
// ----------------------------------------------------------------------------
module fsq_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  fsq_pkg::fsq_item_t push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output fsq_pkg::fsq_item_t pop_item_o,
  input  logic               pop_ready_i
);
  import fsq_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  fsq_item_t       slot_q [FIFO_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PW'(1);
      if (pop)  rd_q <= rd_q + PW'(1);
      if (push && !pop)      cnt_q <= cnt_q + CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= push_item_i;
  end

endmodule

FILE: rtl/fsq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_back: request queue and page sequencer
// Executes one classified item per cycle unless rsp_o stalls: queues submits,
// starts requests on ticks, steps erase/program on completions, registers the result.
// ----------------------------------------------------------------------------
module fsq_back #(
  parameter int unsigned PAGE_BYTES   = 512,
  parameter int unsigned SECTOR_PAGES = 16,
  parameter int unsigned PLANE_BYTES  = 524288,
  parameter int unsigned BOOT_BYTES   = 16384,
  parameter int unsigned QUEUE_DEPTH  = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  fsq_pkg::fsq_item_t in_item_i,
  output logic               in_ready_o,
  fsq_rsp_if.source          rsp_o
);
  import fsq_pkg::*;

  localparam int unsigned SECTOR_BYTES = PAGE_BYTES * SECTOR_PAGES;
  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WW = 15;
  localparam logic [PW-1:0]       LAST_IDX   = PW'(QUEUE_DEPTH - 1);
  localparam logic [OFFSET_W-1:0] PAGE_OFF   = OFFSET_W'(PAGE_BYTES);
  localparam logic [OFFSET_W:0]   PAGE_EXT   = (OFFSET_W+1)'(PAGE_BYTES);
  localparam logic [OFFSET_W:0]   SECT_EXT   = (OFFSET_W+1)'(SECTOR_BYTES);
  localparam logic [OFFSET_W-1:0] SECT_OFF   = OFFSET_W'(SECTOR_BYTES);
  localparam logic [OFFSET_W-1:0] SECT_M1    = OFFSET_W'(SECTOR_BYTES - 1);
  localparam logic [OFFSET_W-1:0] PLANE_OFF  = OFFSET_W'(PLANE_BYTES);
  localparam logic [OFFSET_W:0]   BOOT_EXT   = (OFFSET_W+1)'(BOOT_BYTES);
  localparam logic [LENGTH_W-1:0] PAGE_LEN   = LENGTH_W'(PAGE_BYTES);
  localparam logic [WOFF_W-1:0]   PAGE_WOFF  = WOFF_W'(PAGE_BYTES / 4);
  localparam logic [WW-1:0]       PAGE_WORDS = WW'(PAGE_BYTES / 4);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ERASE,
    PH_PROGRAM
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [OFFSET_W-1:0] sec_start_q, sec_start_d, sec_end_q, sec_end_d;
  logic [OFFSET_W-1:0] cur_off_q, cur_off_d, cur_base_q, cur_base_d;
  logic [LENGTH_W-1:0] remain_q, remain_d;
  logic [WOFF_W-1:0]   woff_q, woff_d;
  logic [CNT_W-1:0]    ok_q, ok_d, err_q, err_d;
  logic [PW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [FW-1:0]       fill_q, fill_d;

  logic                out_valid_q, out_valid_d;
  kind_e               kind_q, kind_d;
  logic                acc_q, acc_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [WORDS_W-1:0]  words_q, words_d;
  logic [WOFF_W-1:0]   owoff_q, owoff_d;

  fsq_req_t            mem [QUEUE_DEPTH];
  fsq_req_t            rd_q;
  fsq_req_t            wdata;

  logic                adv, push, pop;
  logic                do_step, do_prog, do_fail, do_succ;
  logic [OFFSET_W-1:0] nxt_off, nxt_base;
  logic [LENGTH_W-1:0] nxt_remain;
  logic [WW-1:0]       words_full;

  assign adv        = in_valid_i && (!out_valid_q || rsp_o.ready);
  assign in_ready_o = adv;

  assign wdata.offset = in_item_i.write_offset;
  assign wdata.length = in_item_i.write_length;
  assign wdata.base   = in_item_i.sector_base;

  always_comb begin
    // values for the page after the one now being programmed
    nxt_off    = cur_off_q + PAGE_OFF;
    nxt_base   = (({1'b0, cur_off_q} + PAGE_EXT) >= ({1'b0, cur_base_q} + SECT_EXT)) ?
                 cur_base_q + SECT_OFF : cur_base_q;
    nxt_remain = (remain_q >= PAGE_LEN) ? remain_q - PAGE_LEN : '0;

    phase_d     = phase_q;
    sec_start_d = sec_start_q;
    sec_end_d   = sec_end_q;
    cur_off_d   = cur_off_q;
    cur_base_d  = cur_base_q;
    remain_d    = remain_q;
    woff_d      = woff_q;
    ok_d        = ok_q;
    err_d       = err_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    push        = 1'b0;
    pop         = 1'b0;
    do_step     = 1'b0;
    do_prog     = 1'b0;
    do_fail     = 1'b0;
    do_succ     = 1'b0;
    kind_d      = KIND_NOTHING;
    acc_d       = 1'b0;
    addr_d      = '0;
    words_d     = '0;
    owoff_d     = '0;
    words_full  = '0;

    if (adv) begin
      unique case (in_item_i.op)
        OP_SUBMIT: begin
          kind_d = KIND_ACK;
          if (in_item_i.write_length != '0 && fill_q != FW'(QUEUE_DEPTH)) begin
            push  = 1'b1;
            acc_d = 1'b1;
          end
        end
        OP_DONE: begin
          unique case (phase_q)
            PH_ERASE: begin
              if (in_item_i.flash_ok) do_prog = 1'b1;
              else                    do_fail = 1'b1;
            end
            PH_PROGRAM: begin
              if (!in_item_i.flash_ok) begin
                do_fail = 1'b1;
              end else begin
                cur_off_d  = nxt_off;
                cur_base_d = nxt_base;
                remain_d   = nxt_remain;
                woff_d     = woff_q + PAGE_WOFF;
                if (nxt_remain != '0) do_step = 1'b1;
                else                  do_succ = 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (phase_q == PH_IDLE && fill_q != '0) begin
            pop        = 1'b1;
            cur_off_d  = rd_q.offset;
            cur_base_d = rd_q.base;
            remain_d   = rd_q.length;
            woff_d     = '0;
            do_step    = 1'b1;
          end
        end
        OP_INIT: begin
          kind_d      = KIND_INIT_DONE;
          ok_d        = '0;
          err_d       = '0;
          sec_start_d = '1;
          sec_end_d   = '1;
          cur_off_d   = '0;
          cur_base_d  = '0;
          remain_d    = '0;
          woff_d      = '0;
          phase_d     = PH_IDLE;
        end
      endcase
    end

    // page step: the sector hit test ignores the last byte of the sector
    if (do_step) begin
      if (cur_off_d >= sec_start_q && cur_off_d < sec_end_q) begin
        do_prog = 1'b1;
      end else if (cur_off_d >= PLANE_OFF) begin
        do_fail = 1'b1;
      end else begin
        sec_start_d = cur_base_d;
        sec_end_d   = cur_base_d + SECT_M1;
        phase_d     = PH_ERASE;
        kind_d      = KIND_ERASE;
        addr_d      = ADDR_W'(BOOT_EXT + {1'b0, cur_base_d});
      end
    end

    if (do_prog) begin
      words_full = WW'(({1'b0, remain_d} + (LENGTH_W+1)'(3)) >> 2);
      if (words_full > PAGE_WORDS) words_full = PAGE_WORDS;
      phase_d = PH_PROGRAM;
      kind_d  = KIND_PROGRAM;
      addr_d  = ADDR_W'(BOOT_EXT + {1'b0, cur_off_d});
      words_d = words_full[WORDS_W-1:0];
      owoff_d = woff_d;
    end

    if (do_fail) begin
      if (err_q != '1) err_d = err_q + CNT_W'(1);
      phase_d = PH_IDLE;
      kind_d  = KIND_DONE_ERR;
    end

    if (do_succ) begin
      if (ok_q != '1) ok_d = ok_q + CNT_W'(1);
      phase_d = PH_IDLE;
      kind_d  = KIND_DONE_OK;
    end

    if (push) begin
      tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + PW'(1);
      fill_d = fill_q + FW'(1);
    end
    if (pop) begin
      head_d = (head_q == LAST_IDX) ? '0 : head_q + PW'(1);
      fill_d = fill_q - FW'(1);
    end

    if (adv)              out_valid_d = 1'b1;
    else if (rsp_o.ready) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      sec_start_q <= '1;
      sec_end_q   <= '1;
      cur_off_q   <= '0;
      cur_base_q  <= '0;
      remain_q    <= '0;
      woff_q      <= '0;
      ok_q        <= '0;
      err_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NOTHING;
      acc_q       <= 1'b0;
      addr_q      <= '0;
      words_q     <= '0;
      owoff_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      sec_start_q <= sec_start_d;
      sec_end_q   <= sec_end_d;
      cur_off_q   <= cur_off_d;
      cur_base_q  <= cur_base_d;
      remain_q    <= remain_d;
      woff_q      <= woff_d;
      ok_q        <= ok_d;
      err_q       <= err_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        kind_q  <= kind_d;
        acc_q   <= acc_d;
        addr_q  <= addr_d;
        words_q <= words_d;
        owoff_q <= owoff_d;
      end
    end
  end

  // Request store: one write port, registered read of the next head entry
  // with forwarding when that entry is being written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (push) mem[tail_q] <= wdata;
    if (push && tail_q == head_d) rd_q <= wdata;
    else                          rd_q <= mem[head_d];
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.kind             = kind_q;
  assign rsp_o.accepted         = acc_q;
  assign rsp_o.flash_address    = addr_q;
  assign rsp_o.word_count       = words_q;
  assign rsp_o.data_word_offset = owoff_q;
  assign rsp_o.ok_count         = ok_q;
  assign rsp_o.error_count      = err_q;

endmodule

FILE: rtl/flash_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_write_sequencer: queued flash write sequencer
// Queues write requests and walks each one through sector erases and page
// programs, driven by tick and flash completion items.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation item per handshake (valid && ready): submit,
//   flash completion (with flash_ok), tick or init. rsp_o returns exactly one
//   result item per input item, in order: submit ack, erase or program
//   command, request done ok/error, nothing, or init done, with the running
//   success and error counts.
//   Throughput: one item per cycle while rsp_o is ready; the front classifier,
//   four-entry item queue and back sequencer each take one item a cycle.
//   The back reads its request store through a registered read port that
//   always holds the next head entry, so a tick starts it without a read.
//   When rsp_o stalls, the back holds its result register and stops; the
//   front keeps accepting until the item queue and its own pipeline fill,
//   then deasserts req_i.ready.
//   Reset clears the counters, the sector record (to no sector), queue
//   pointers and all valid flags; the request store content is not cleared
//   and only written entries are ever read.
// ----------------------------------------------------------------------------
module flash_write_sequencer #(
  parameter int unsigned PAGE_BYTES   = 512,
  parameter int unsigned SECTOR_PAGES = 16,
  parameter int unsigned PLANE_BYTES  = 524288,
  parameter int unsigned BOOT_BYTES   = 16384,
  parameter int unsigned QUEUE_DEPTH  = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsq_req_if.sink   req_i,
  fsq_rsp_if.source rsp_o
);
  import fsq_pkg::*;

  // front -> item queue
  logic      front_valid, front_ready;
  fsq_item_t front_item;
  // item queue -> back
  logic      back_valid, back_ready;
  fsq_item_t back_item;

  // Intake: registers items and works out each offset's sector start.
  fsq_front #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_PAGES (SECTOR_PAGES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .out_valid_o (front_valid),
    .out_item_o  (front_item),
    .out_ready_i (front_ready)
  );

  // Decouples intake from execution so either side can stall alone.
  fsq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_item_i  (front_item),
    .push_ready_o (front_ready),
    .pop_valid_o  (back_valid),
    .pop_item_o   (back_item),
    .pop_ready_i  (back_ready)
  );

  // Execution: request store, erase/program sequencing, counters, result reg.
  fsq_back #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_PAGES (SECTOR_PAGES),
    .PLANE_BYTES  (PLANE_BYTES),
    .BOOT_BYTES   (BOOT_BYTES),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (back_valid),
    .in_item_i  (back_item),
    .in_ready_o (back_ready),
    .rsp_o      (rsp_o)
  );

endmodule

FILE: rtl/fsq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_checker: port-level checks of the flash write sequencer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module fsq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [fsq_pkg::KIND_W-1:0]  kind_i,
  input logic                        accepted_i,
  input logic [fsq_pkg::ADDR_W-1:0]  flash_address_i,
  input logic [fsq_pkg::WORDS_W-1:0] word_count_i,
  input logic [fsq_pkg::WOFF_W-1:0]  data_word_offset_i,
  input logic [fsq_pkg::CNT_W-1:0]   ok_count_i,
  input logic [fsq_pkg::CNT_W-1:0]   error_count_i
);
  import fsq_pkg::*;

  // A stalled result stays offered with kind, address and counts unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(kind_i) &&
      $stable(flash_address_i) && $stable(ok_count_i) && $stable(error_count_i))
    else $error("result changed while stalled");

  // Accept flag only rides on submit acks.
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && accepted_i |-> kind_i == KIND_ACK)
    else $error("accepted set outside submit ack");

  // Init reports cleared counters.
  a_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && kind_i == KIND_INIT_DONE |-> ok_count_i == '0 && error_count_i == '0)
    else $error("counters not cleared on init");

  // Command fields are zero for results that are not flash commands.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && kind_i != KIND_ERASE && kind_i != KIND_PROGRAM |->
      flash_address_i == '0 && word_count_i == '0 && data_word_offset_i == '0)
    else $error("command fields set on non-command result");

  // A successful completion leaves a nonzero success count.
  a_okcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && kind_i == KIND_DONE_OK |-> ok_count_i != '0)
    else $error("done ok with zero success count");

endmodule

bind flash_write_sequencer fsq_checker u_fsq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .kind_i             (rsp_o.kind),
  .accepted_i         (rsp_o.accepted),
  .flash_address_i    (rsp_o.flash_address),
  .word_count_i       (rsp_o.word_count),
  .data_word_offset_i (rsp_o.data_word_offset),
  .ok_count_i         (rsp_o.ok_count),
  .error_count_i      (rsp_o.error_count)
);
